// File: sv/jet_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Julia set escape-time core.
// No dependencies; imported by every module of the block.
package jet_pkg;

  // Fixed-point format of all plane coordinates (signed Q4.28).
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // Escape threshold 4.0 expressed with 2*FRAC_BITS fraction bits.
  localparam int unsigned ESC_SHIFT = 2 * FRAC_BITS + 2;
  localparam bit          ESC_OK    = (ESC_SHIFT < PROD_W);
  localparam logic [PROD_W-1:0] ESC_THR =
    ESC_OK ? (PROD_W'(1) << ESC_SHIFT) : '0;

  localparam logic [CNT_W-1:0] ITER_LIMIT_RST = CNT_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONST_REAL = 2'd0,
    CFG_CONST_IMAG = 2'd1,
    CFG_ITER_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } jet_state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] c_re;
    logic signed [DATA_W-1:0] c_im;
    logic [CNT_W-1:0]         limit;
  } jet_cfg_t;

  typedef struct packed {
    logic load;      // capture the starting point, clear count and flag
    logic mul;       // register the three products of the current z
    logic step;      // write back the updated z and bump the count
    logic set_esc;   // mark the point as escaped
    logic out_load;  // move count and flag into the output register
  } jet_cmd_t;

  typedef struct packed {
    logic escape;    // |z|^2 of the registered products exceeds 4
    logic last;      // the step being taken is the final allowed one
  } jet_status_t;

endpackage

// File: sv/julia_escape_time_core.sv
`timescale 1ns / 1ps
// Julia set escape-time core. Each step of a point runs a product state on three
// shared 32x32 multipliers, then an update state; a zero limit takes no step. A new
// point is accepted only in the idle state, after the previous result has moved into
// the output register. Asynchronous active-low reset clears control state and sets
// c = 0 and the iteration limit to 100.
module julia_escape_time_core import jet_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] start_real_i,
  input  logic signed [DATA_W-1:0] start_imag_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [CNT_W-1:0]         iter_count_o,
  output logic                     escaped_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i
);

  jet_cfg_t    cfg;
  jet_cmd_t    cmd;
  jet_status_t status;

  jet_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  jet_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .limit_zero_i (cfg.limit == '0),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  jet_dp u_dp (
    .clk_i        (clk_i),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .start_real_i (start_real_i),
    .start_imag_i (start_imag_i),
    .iter_count_o (iter_count_o),
    .escaped_o    (escaped_o)
  );

`ifndef NO_ASSERTIONS
  // An escaped point always stops short of the limit.
  a_esc_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && escaped_o |-> iter_count_o < cfg.limit)
    else $error("escaped result with count at or above the limit");

  // A point that did not escape ran exactly the configured number of steps.
  a_full_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !escaped_o |-> iter_count_o == cfg.limit)
    else $error("non-escaped result with count different from the limit");

  // With a nonzero limit at least one step runs, so no result appears right away.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cfg.limit != '0) |=> !$rose(out_valid_o))
    else $error("result presented one cycle after accepting a point");
`endif

endmodule

// File: sv/jet_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: Julia constant c and the iteration limit.
// Depends on jet_pkg.
module jet_cfg import jet_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output jet_cfg_t             cfg_o
);

  jet_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CONST_REAL: cfg_d.c_re  = cfg_data_i;
        CFG_CONST_IMAG: cfg_d.c_im  = cfg_data_i;
        CFG_ITER_LIMIT: cfg_d.limit = cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.c_re  <= '0;
      cfg_q.c_im  <= '0;
      cfg_q.limit <= ITER_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/jet_dp.sv
`timescale 1ns / 1ps
// Datapath: z register, product registers, update with saturation, count and result.
// Depends on jet_pkg; driven by jet_ctrl commands.
module jet_dp import jet_pkg::*; (
  input  logic                     clk_i,
  input  jet_cfg_t                 cfg_i,
  input  jet_cmd_t                 cmd_i,
  output jet_status_t              status_o,
  input  logic signed [DATA_W-1:0] start_real_i,
  input  logic signed [DATA_W-1:0] start_imag_i,
  output logic [CNT_W-1:0]         iter_count_o,
  output logic                     escaped_o
);

  localparam int unsigned SUM_W = PROD_W + 2;

  logic signed [DATA_W-1:0] re_q, im_q;
  logic signed [PROD_W-1:0] re2_q, im2_q, reim_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     esc_q;
  logic [CNT_W-1:0]         iter_count_q;
  logic                     escaped_q;

  logic [PROD_W-1:0]        mag;
  logic signed [PROD_W-1:0] diff, diff_sh, reim_sh;
  logic signed [SUM_W-1:0]  nre_full, nim_full;
  logic signed [DATA_W-1:0] nre, nim;

  // Clamp a wide signed value into the DATA_W signed range.
  function automatic logic signed [DATA_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic top_same;
    top_same = (v[SUM_W-1:DATA_W-1] == '0) || (v[SUM_W-1:DATA_W-1] == '1);
    if (top_same) begin
      sat = v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // Both squares are non-negative and at most 2^62, so the sum never wraps.
  assign mag     = $unsigned(re2_q) + $unsigned(im2_q);
  assign diff    = re2_q - im2_q;
  assign diff_sh = diff >>> FRAC_BITS;
  // 2*re*im scaled back is the product shifted by one bit less.
  assign reim_sh = reim_q >>> (FRAC_BITS - 1);

  assign nre_full = {{(SUM_W-PROD_W){diff_sh[PROD_W-1]}}, diff_sh}
                  + {{(SUM_W-DATA_W){cfg_i.c_re[DATA_W-1]}}, cfg_i.c_re};
  assign nim_full = {{(SUM_W-PROD_W){reim_sh[PROD_W-1]}}, reim_sh}
                  + {{(SUM_W-DATA_W){cfg_i.c_im[DATA_W-1]}}, cfg_i.c_im};
  assign nre = sat(nre_full);
  assign nim = sat(nim_full);

  assign status_o.escape = ESC_OK && (mag > ESC_THR);
  assign status_o.last   = ((cnt_q + CNT_W'(1)) == cfg_i.limit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      re_q  <= start_real_i;
      im_q  <= start_imag_i;
      cnt_q <= '0;
      esc_q <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        re_q  <= nre;
        im_q  <= nim;
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.set_esc) begin
        esc_q <= 1'b1;
      end
    end
    if (cmd_i.mul) begin
      re2_q  <= PROD_W'(re_q) * PROD_W'(re_q);
      im2_q  <= PROD_W'(im_q) * PROD_W'(im_q);
      reim_q <= PROD_W'(re_q) * PROD_W'(im_q);
    end
    if (cmd_i.out_load) begin
      iter_count_q <= cnt_q;
      escaped_q    <= esc_q;
    end
  end

  assign iter_count_o = iter_count_q;
  assign escaped_o    = escaped_q;

endmodule

// File: sv/jet_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences multiply and update cycles per point
// and owns the input and output handshakes. Depends on jet_pkg.
module jet_ctrl import jet_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        limit_zero_i,
  input  jet_status_t status_i,
  output jet_cmd_t    cmd_o
);

  jet_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = limit_zero_i ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        if (status_i.escape) begin
          cmd_o.set_esc = 1'b1;
          state_d       = ST_FIN;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = status_i.last ? ST_FIN : ST_MUL;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: tb/sv/julia_escape_time_checker.sv
`timescale 1ns / 1ps
// Result checker for the Julia set escape-time core: mirrors the configuration
// registers, predicts the step count and escape flag of every point, and checks each result.
// Depends on jet_pkg for widths, the escape threshold and the register indexes.
module julia_escape_time_checker import jet_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic signed [DATA_W-1:0] start_real_i,
  input  logic signed [DATA_W-1:0] start_imag_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [CNT_W-1:0]         iter_count_i,
  input  logic                     escaped_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  localparam longint Q_MAX      = (longint'(1) << (DATA_W - 1)) - 1;
  localparam longint Q_MIN      = -(longint'(1) << (DATA_W - 1));
  localparam int     REPORT_MAX = 10;

  typedef struct {
    logic signed [DATA_W-1:0] z_re;
    logic signed [DATA_W-1:0] z_im;
    logic [CNT_W-1:0]         count;
    logic                     escaped;
  } orbit_result_t;

  longint           c_re;
  longint           c_im;
  logic [CNT_W-1:0] max_steps;
  orbit_result_t    expected_orbits[$];
  int               mismatches;

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic orbit_result_t predict_orbit(logic signed [DATA_W-1:0] z_re,
                                                  logic signed [DATA_W-1:0] z_im);
    longint            re;
    longint            im;
    longint            re_sq;
    longint            im_sq;
    longint            next_re;
    longint            next_im;
    logic [PROD_W-1:0] mag;
    int unsigned       steps;
    orbit_result_t     r;
    re        = longint'(z_re);
    im        = longint'(z_im);
    steps     = 0;
    r.z_re    = z_re;
    r.z_im    = z_im;
    r.escaped = 1'b0;
    while (steps < max_steps) begin
      re_sq = re * re;
      im_sq = im * im;
      // The sum of squares is taken as unsigned so that 2^63 still compares correctly.
      mag = $unsigned(re_sq) + $unsigned(im_sq);
      if (ESC_OK && mag > ESC_THR) begin
        r.escaped = 1'b1;
        break;
      end
      // Arithmetic shifts round toward minus infinity; one bit less gives the factor 2.
      next_im = ((re * im) >>> (FRAC_BITS - 1)) + c_im;
      next_re = ((re_sq - im_sq) >>> FRAC_BITS) + c_re;
      im      = clamp_q(next_im);
      re      = clamp_q(next_re);
      steps++;
    end
    r.count = CNT_W'(steps);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    orbit_result_t head;
    if (!rst_ni) begin
      c_re      <= 0;
      c_im      <= 0;
      max_steps <= ITER_LIMIT_RST;
      expected_orbits.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // The oldest expectation is retired before a new point is queued.
      if (out_valid_i && !out_stall_i) begin
        if (expected_orbits.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result transaction: count %0d escaped %0b",
                     $time, iter_count_i, escaped_i);
        end else begin
          head = expected_orbits.pop_front();
          if (iter_count_i !== head.count || escaped_i !== head.escaped) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: point (%0d, %0d): expected count %0d escaped %0b, got %0d %0b",
                       $time, head.z_re, head.z_im, head.count, head.escaped,
                       iter_count_i, escaped_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_orbits.push_back(predict_orbit(start_real_i, start_imag_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CONST_REAL: c_re      <= longint'($signed(cfg_data_i));
          CFG_CONST_IMAG: c_im      <= longint'($signed(cfg_data_i));
          CFG_ITER_LIMIT: max_steps <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_orbits.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the escape-time core testbench: clock, reset, register writes, point and
// stall stimulus, watchdog and verdict. Uses jet_pkg and julia_escape_time_checker.
module tb;
  import jet_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 2 * (2 ** CNT_W) + 8;
  localparam int RANDOM_ITEMS   = 600;
  localparam int Q_ONE          = 1 << FRAC_BITS;
  localparam int Q_TWO          = 2 * Q_ONE;
  localparam int Q_MAX          = 2147483647;
  localparam int Q_MIN          = -2147483647 - 1;
  localparam int LIMIT_MAX      = (2 ** CNT_W) - 1;

  // Index with no register behind it; writes to it must leave everything unchanged.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] start_real = '0;
  logic signed [DATA_W-1:0] start_imag = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [CNT_W-1:0]         iter_count;
  logic                     escaped;
  logic                     cfg_valid  = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index  = '0;
  logic [DATA_W-1:0]        cfg_data   = '0;
  int                       fail_count;
  int                       pending;
  int                       quiet_cycles = 0;
  bit                       bursty       = 1'b1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  julia_escape_time_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .start_real_i (start_real),
    .start_imag_i (start_imag),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .iter_count_o (iter_count),
    .escaped_o    (escaped),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  julia_escape_time_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .start_real_i (start_real),
    .start_imag_i (start_imag),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .iter_count_i (iter_count),
    .escaped_i    (escaped),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rnd_in(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_point(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im);
    int gap;
    gap = bursty ? idle_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    start_real <= re;
    start_imag <= im;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every point sent so far has produced its result.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic configure(input logic [DATA_W-1:0] c_re, input logic [DATA_W-1:0] c_im,
                           input logic [DATA_W-1:0] limit_word);
    settle();
    write_reg(CFG_CONST_REAL, c_re);
    write_reg(CFG_CONST_IMAG, c_im);
    write_reg(CFG_ITER_LIMIT, limit_word);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result stall pattern: stretches of random stalls alternate with stretches without.
  initial begin : stall_gen
    int  span;
    int  len;
    bit  calm;
    wait (rst_n);
    forever begin
      calm = ($urandom_range(0, 3) == 0);
      span = $urandom_range(100, 400);
      while (span > 0) begin
        len = calm ? 0 : idle_len();
        repeat (len) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        @(negedge clk);
        out_stall <= 1'b0;
        span -= len + 1;
      end
    end
  end

  initial begin : stimulus
    int               sent;
    int               batch;
    int               pick;
    int               lim;
    int               c_re;
    int               c_im;
    logic [DATA_W-1:0] limit_word;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: c = 0, limit 100.
    send_point(0, 0);
    send_point(Q_TWO, 0);          // |z|^2 exactly 4 does not escape at the first check
    send_point(Q_TWO + 1, 0);      // just outside the circle
    send_point(0, -Q_TWO);
    send_point(Q_MIN, Q_MIN);
    send_point(Q_MAX, Q_MAX);
    send_point(Q_MIN, Q_MAX);
    send_point(Q_MAX, Q_MIN);
    send_point(Q_ONE, 0);
    send_point(-Q_ONE, 0);
    send_point(0, Q_ONE);
    send_point(-1, 1);             // floor rounding of a tiny negative product
    send_point(-1, -1);

    // Extreme constants, so updated parts saturate at both ends.
    configure(Q_MAX, Q_MIN, 1);
    send_point(0, 0);
    send_point(Q_TWO, 0);
    send_point(Q_ONE, -Q_ONE);
    send_point(Q_MIN, Q_MAX);

    configure(Q_MIN, Q_MAX, LIMIT_MAX);
    send_point(0, 0);
    send_point(Q_TWO, 0);

    // Points that never escape run to the largest limit. A write to the spare index
    // carrying 2.0 would change the outcome if it landed in any register.
    configure(0, 0, LIMIT_MAX);
    write_reg(CFG_SPARE_IDX, Q_TWO);
    send_point(0, 0);
    send_point(Q_ONE / 2, 0);
    send_point(Q_ONE, 0);

    // A zero limit takes no step, whatever the point.
    configure($urandom(), $urandom(), 0);
    send_point(Q_MIN, Q_MIN);
    send_point(0, 0);
    send_point(Q_MAX, 1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        c_re = rnd_in(Q_ONE);
        c_im = rnd_in(Q_ONE);
      end else if (pick < 8) begin
        // Well-known constants near the set boundary give long, varied orbits.
        case ($urandom_range(0, 3))
          0:       begin c_re = -214748365; c_im = 41875931;  end
          1:       begin c_re = -107374182; c_im = 161061274; end
          2:       begin c_re = 76504268;   c_im = 2684355;   end
          default: begin c_re = -195125733; c_im = 50707458;  end
        endcase
        c_re += rnd_in(1 << 16);
        c_im += rnd_in(1 << 16);
      end else begin
        c_re = $urandom();
        c_im = $urandom();
      end

      batch = $urandom_range(30, 50);
      pick  = $urandom_range(0, 19);
      if (pick < 10) begin
        lim = $urandom_range(1, 32);
      end else if (pick < 15) begin
        lim = $urandom_range(33, 150);
      end else if (pick < 18) begin
        lim = $urandom_range(151, 300);
      end else if (pick == 18) begin
        lim   = LIMIT_MAX;
        batch = 10;
      end else begin
        lim = $urandom_range(0, 1);
      end
      // Bits above the limit field carry random values and must be dropped.
      limit_word           = $urandom();
      limit_word[CNT_W-1:0] = CNT_W'(lim);
      configure(c_re, c_im, limit_word);
      if ($urandom_range(0, 4) == 0)
        write_reg(CFG_SPARE_IDX, $urandom());

      bursty = ($urandom_range(0, 3) != 0);
      repeat (batch) begin
        pick = $urandom_range(0, 19);
        if (pick < 14)
          send_point(rnd_in(Q_TWO), rnd_in(Q_TWO));
        else if (pick < 17)
          send_point(rnd_in(Q_ONE / 2), rnd_in(Q_ONE / 2));
        else
          send_point($urandom(), $urandom());
      end
      sent += batch;
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: julia_escape_time_core.f
sv/jet_pkg.sv
sv/jet_cfg.sv
sv/jet_dp.sv
sv/jet_ctrl.sv
sv/julia_escape_time_core.sv
tb/sv/julia_escape_time_checker.sv
tb/sv/tb.sv
